### hw/rtl/des_pkg.sv
// DES constants, permutation tables and bit-level helper functions.
package des_pkg;

   localparam int RoundCount = 16;

   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   typedef logic [5:0] tab_entry_type;
   typedef logic [3:0] nib_type;

   // stage payload handed from one round cell to the next
   typedef struct packed {
      logic        vld;
      logic        dec;
      logic [31:0] left;
      logic [31:0] right;
      logic [27:0] c;
      logic [27:0] d;
   } stage_type;

   localparam tab_entry_type TabIp [64] = '{
      6'd57, 6'd49, 6'd41, 6'd33, 6'd25, 6'd17, 6'd9,  6'd1,
      6'd59, 6'd51, 6'd43, 6'd35, 6'd27, 6'd19, 6'd11, 6'd3,
      6'd61, 6'd53, 6'd45, 6'd37, 6'd29, 6'd21, 6'd13, 6'd5,
      6'd63, 6'd55, 6'd47, 6'd39, 6'd31, 6'd23, 6'd15, 6'd7,
      6'd56, 6'd48, 6'd40, 6'd32, 6'd24, 6'd16, 6'd8,  6'd0,
      6'd58, 6'd50, 6'd42, 6'd34, 6'd26, 6'd18, 6'd10, 6'd2,
      6'd60, 6'd52, 6'd44, 6'd36, 6'd28, 6'd20, 6'd12, 6'd4,
      6'd62, 6'd54, 6'd46, 6'd38, 6'd30, 6'd22, 6'd14, 6'd6
   };
   // entries are (standard position - 1); 64 is stored as 63 etc.

   localparam tab_entry_type TabIpInv [64] = '{
      6'd39, 6'd7, 6'd47, 6'd15, 6'd55, 6'd23, 6'd63, 6'd31,
      6'd38, 6'd6, 6'd46, 6'd14, 6'd54, 6'd22, 6'd62, 6'd30,
      6'd37, 6'd5, 6'd45, 6'd13, 6'd53, 6'd21, 6'd61, 6'd29,
      6'd36, 6'd4, 6'd44, 6'd12, 6'd52, 6'd20, 6'd60, 6'd28,
      6'd35, 6'd3, 6'd43, 6'd11, 6'd51, 6'd19, 6'd59, 6'd27,
      6'd34, 6'd2, 6'd42, 6'd10, 6'd50, 6'd18, 6'd58, 6'd26,
      6'd33, 6'd1, 6'd41, 6'd9,  6'd49, 6'd17, 6'd57, 6'd25,
      6'd32, 6'd0, 6'd40, 6'd8,  6'd48, 6'd16, 6'd56, 6'd24
   };

   localparam tab_entry_type TabExp [48] = '{
      6'd31, 6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd3,  6'd4,
      6'd5,  6'd6,  6'd7,  6'd8,  6'd7,  6'd8,  6'd9,  6'd10,
      6'd11, 6'd12, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16,
      6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd19, 6'd20,
      6'd21, 6'd22, 6'd23, 6'd24, 6'd23, 6'd24, 6'd25, 6'd26,
      6'd27, 6'd28, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd0
   };

   localparam tab_entry_type TabPbox [32] = '{
      6'd15, 6'd6,  6'd19, 6'd20, 6'd28, 6'd11, 6'd27, 6'd16,
      6'd0,  6'd14, 6'd22, 6'd25, 6'd4,  6'd17, 6'd30, 6'd9,
      6'd1,  6'd7,  6'd23, 6'd13, 6'd31, 6'd26, 6'd2,  6'd8,
      6'd18, 6'd12, 6'd29, 6'd5,  6'd21, 6'd10, 6'd3,  6'd24
   };

   localparam tab_entry_type TabPc1 [56] = '{
      6'd56, 6'd48, 6'd40, 6'd32, 6'd24, 6'd16, 6'd8,
      6'd0,  6'd57, 6'd49, 6'd41, 6'd33, 6'd25, 6'd17,
      6'd9,  6'd1,  6'd58, 6'd50, 6'd42, 6'd34, 6'd26,
      6'd18, 6'd10, 6'd2,  6'd59, 6'd51, 6'd43, 6'd35,
      6'd62, 6'd54, 6'd46, 6'd38, 6'd30, 6'd22, 6'd14,
      6'd6,  6'd61, 6'd53, 6'd45, 6'd37, 6'd29, 6'd21,
      6'd13, 6'd5,  6'd60, 6'd52, 6'd44, 6'd36, 6'd28,
      6'd20, 6'd12, 6'd4,  6'd27, 6'd19, 6'd11, 6'd3
   };

   localparam tab_entry_type TabPc2 [48] = '{
      6'd13, 6'd16, 6'd10, 6'd23, 6'd0,  6'd4,  6'd2,  6'd27,
      6'd14, 6'd5,  6'd20, 6'd9,  6'd22, 6'd18, 6'd11, 6'd3,
      6'd25, 6'd7,  6'd15, 6'd6,  6'd26, 6'd19, 6'd12, 6'd1,
      6'd40, 6'd51, 6'd30, 6'd36, 6'd46, 6'd54, 6'd29, 6'd39,
      6'd50, 6'd44, 6'd32, 6'd47, 6'd43, 6'd48, 6'd38, 6'd55,
      6'd33, 6'd52, 6'd45, 6'd41, 6'd49, 6'd35, 6'd28, 6'd31
   };

   // one-position shift schedule; a 0 entry means shift by two
   localparam logic [RoundCount-1:0] RotOne = 16'b1100_0000_1000_0001;

   localparam nib_type SBox [8][64] = '{
      '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
        4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
        4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
        4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
      '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
        4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
        4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
        4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
      '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
        4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
        4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
        4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
      '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
        4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
        4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
        4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
      '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
        4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
        4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
        4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
      '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
        4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
        4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
        4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
      '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
        4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
        4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
        4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
      '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
        4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
        4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
        4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
   };

   // entries are 0-based positions counted from the most significant bit
   function automatic logic [63:0] perm_ip(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) r[63-i] = v[63-TabIp[i]];
      return r;
   endfunction

   function automatic logic [63:0] perm_ip_inv(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) r[63-i] = v[63-TabIpInv[i]];
      return r;
   endfunction

   function automatic logic [55:0] perm_pc1(input logic [63:0] v);
      logic [55:0] r;
      for (int i = 0; i < 56; i++) r[55-i] = v[63-TabPc1[i]];
      return r;
   endfunction

   function automatic logic [47:0] perm_pc2(input logic [55:0] v);
      logic [47:0] r;
      for (int i = 0; i < 48; i++) r[47-i] = v[55-TabPc2[i]];
      return r;
   endfunction

   function automatic logic [31:0] feistel(input logic [31:0] half, input logic [47:0] sk);
      logic [47:0] x;
      logic [31:0] s;
      logic [31:0] r;
      logic [5:0]  six;
      for (int i = 0; i < 48; i++) x[47-i] = half[31-TabExp[i]];
      x = x ^ sk;
      for (int i = 0; i < 8; i++) begin
         six = x[47-6*i -: 6];
         s[31-4*i -: 4] = SBox[i][{six[5], six[0], six[4:1]}];
      end
      for (int i = 0; i < 32; i++) r[31-i] = s[31-TabPbox[i]];
      return r;
   endfunction

   function automatic logic [27:0] rotl(input logic [27:0] x, input logic one);
      return one ? {x[26:0], x[27]} : {x[25:0], x[27:26]};
   endfunction

   function automatic logic [27:0] rotr(input logic [27:0] x, input logic one);
      return one ? {x[0], x[27:1]} : {x[1:0], x[27:2]};
   endfunction

endpackage

### hw/rtl/des_round_cell.sv
// One DES round cell: key rotation, Feistel round, registered hand-off.
module des_round_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                rot_one,
   input  logic                rot_back,
   input  logic                last,
   input  des_pkg::stage_type  prev,
   output des_pkg::stage_type  next
);
   import des_pkg::*;

   stage_type   stage_ff;
   stage_type   stage_in;
   logic [27:0] c_sk;
   logic [27:0] d_sk;
   logic [31:0] f_out;

   // encrypt rotates left before use; decrypt uses the key then rotates right
   // by the shift of the mirrored round
   always_comb begin
      if (prev.dec == CMD_DECRYPT) begin
         c_sk = prev.c;
         d_sk = prev.d;
      end else begin
         c_sk = rotl(prev.c, rot_one);
         d_sk = rotl(prev.d, rot_one);
      end
      f_out = feistel(prev.right, perm_pc2({c_sk, d_sk}));
      stage_in       = prev;
      stage_in.left  = last ? (prev.left ^ f_out) : prev.right;
      stage_in.right = last ? prev.right : (prev.left ^ f_out);
      if (prev.dec == CMD_DECRYPT) begin
         stage_in.c = rotr(prev.c, rot_back);
         stage_in.d = rotr(prev.d, rot_back);
      end else begin
         stage_in.c = c_sk;
         stage_in.d = d_sk;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.vld <= 1'b0;
      end else begin
         stage_ff.vld <= prev.vld;
      end
      stage_ff.dec   <= stage_in.dec;
      stage_ff.left  <= stage_in.left;
      stage_ff.right <= stage_in.right;
      stage_ff.c     <= stage_in.c;
      stage_ff.d     <= stage_in.d;
   end

   assign next = stage_ff;

endmodule

### hw/rtl/des_block_cipher.sv
// DES block cipher top level: key register, initial permutation, round chain, output.
// A start beat passes the 16 round-cell registers and the output register on its way to rsp_valid.
// Throughput: one beat per cycle; busy is tied low and blocks never stall.
// Each of the 16 round cells holds one block in flight and its key halves.
// Reset (synchronous, active high) clears the key register and all valid bits.
// The receiver cannot stall: each result shows for exactly one cycle.
module des_block_cipher (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [63:0] req_data_block,
   input  logic        csr_write,
   input  logic [63:0] csr_cipher_key,
   output logic        rsp_valid,
   output logic [63:0] rsp_result_block
);
   import des_pkg::*;

   logic [63:0] key_ff;
   logic [63:0] ip_out;
   logic [55:0] cd0;
   logic [63:0] res_in;
   logic [63:0] res_ff;
   logic        vld_ff;
   stage_type   chain [RoundCount+1];

   // hold the key; the user must write it only while the pipe is empty (not enforced here)
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_write) begin
         key_ff <= csr_cipher_key;
      end
   end

   // no back-pressure: accept a beat every cycle
   assign busy = 1'b0;

   // first cell input: permuted halves and PC-1 key halves
   always_comb begin
      ip_out = perm_ip(req_data_block);
      cd0    = perm_pc1(key_ff);
      chain[0].vld   = start;
      chain[0].dec   = req_command;
      chain[0].left  = ip_out[63:32];
      chain[0].right = ip_out[31:0];
      // decrypt starts from K16, whose halves equal the unrotated ones
      chain[0].c     = cd0[55:28];
      chain[0].d     = cd0[27:0];
   end

   // decrypt cell g steps back by the shift of round 15-g
   for (genvar g = 0; g < RoundCount; g++) begin : g_round
      des_round_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .rot_one  (RotOne[RoundCount-1-g]),
         .rot_back (RotOne[g]),
         .last     (g == RoundCount - 1),
         .prev     (chain[g]),
         .next     (chain[g+1])
      );
   end

   // last cell already skipped the swap; apply the inverse permutation
   assign res_in = perm_ip_inv({chain[RoundCount].left, chain[RoundCount].right});

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= chain[RoundCount].vld;
      end
      res_ff <= res_in;
   end

   assign rsp_valid        = vld_ff;
   assign rsp_result_block = res_ff;

   // a strobe always traces back to a start beat, through the round cells and output register
   a_lat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, RoundCount + 1))
      else $error("strobe without matching start");
   a_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");
   a_key: assert property (@(posedge clock) disable iff (reset)
      !$past(csr_write) |-> $stable(key_ff))
      else $error("key changed without write");

endmodule

### bench/tb.sv
// Self-checking bench for the DES block cipher: random and known-answer blocks.
`timescale 1ns / 1ps

module tb;
   import des_pkg::*;

   localparam int LATENCY   = 17;
   localparam int MAX_CYCLE = 400000;

   typedef struct {
      logic        cmd;
      logic [63:0] blk;
   } beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_command = CMD_ENCRYPT;
   logic [63:0] req_data_block = '0;
   logic        csr_write = 1'b0;
   logic [63:0] csr_cipher_key = '0;
   logic        rsp_valid;
   logic [63:0] rsp_result_block;

   beat_type    pending_q[$];
   logic [63:0] cipher_out_q[$];
   logic [63:0] key_shadow = '0;
   int          error_count = 0;
   int          cycle_count = 0;
   int          gap_left = 0;
   int          burst_left = 0;

   // standard DES tables, one-based bit numbers counted from the MSB
   byte ip_map[64] = '{58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
      62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,57,49,41,33,25,17,9,1,
      59,51,43,35,27,19,11,3,61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
   byte ip_inv_map[64] = '{40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
      38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,36,4,44,12,52,20,60,28,
      35,3,43,11,51,19,59,27,34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
   byte exp_map[48] = '{32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,
      16,17,16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
   byte p_map[32] = '{16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
   byte pc1_map[56] = '{57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,
      35,27,19,11,3,60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,
      14,6,61,53,45,37,29,21,13,5,28,20,12,4};
   byte pc2_map[48] = '{14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,
      27,20,13,2,41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,
      50,36,29,32};
   byte shift_sched[16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
   byte sbox_tab[8][64] = '{
      '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
      '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
      '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
      '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
      '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
      '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
      '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
      '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

   des_block_cipher DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_data_block(req_data_block),
      .csr_write(csr_write), .csr_cipher_key(csr_cipher_key),
      .rsp_valid(rsp_valid), .rsp_result_block(rsp_result_block)
   );

   always #2 clock = ~clock;

   // gather n bits of a w-bit word in map order, bit 1 being the MSB
   function automatic logic [63:0] gather(logic [63:0] v, byte map[], int n, int w);
      logic [63:0] acc;
      acc = '0;
      for (int i = 0; i < n; i++) acc = {acc[62:0], v[w - map[i]]};
      return acc;
   endfunction

   function automatic logic [31:0] mix_half(logic [31:0] half, logic [47:0] sk);
      logic [47:0] x;
      logic [31:0] s;
      logic [5:0]  six;
      x = 48'(gather({32'h0, half}, exp_map, 48, 32)) ^ sk;
      for (int i = 0; i < 8; i++) begin
         six = x[47-6*i -: 6];
         s[31-4*i -: 4] = 4'(sbox_tab[i][{six[5], six[0]} * 16 + six[4:1]]);
      end
      return 32'(gather({32'h0, s}, p_map, 32, 32));
   endfunction

   function automatic logic [63:0] des_transform(logic [63:0] key, logic cmd, logic [63:0] blk);
      logic [47:0] sub[16];
      logic [55:0] cd;
      logic [27:0] c, d;
      logic [63:0] p;
      logic [31:0] l, r, prev;
      cd = 56'(gather(key, pc1_map, 56, 64));
      c = cd[55:28];
      d = cd[27:0];
      for (int k = 0; k < 16; k++) begin
         repeat (shift_sched[k]) begin
            c = {c[26:0], c[27]};
            d = {d[26:0], d[27]};
         end
         sub[k] = 48'(gather({8'h0, c, d}, pc2_map, 48, 56));
      end
      p = gather(blk, ip_map, 64, 64);
      l = p[63:32];
      r = p[31:0];
      for (int k = 0; k < 16; k++) begin
         prev = r;
         r = l ^ mix_half(r, sub[cmd == CMD_DECRYPT ? 15 - k : k]);
         l = prev;
      end
      return gather({r, l}, ip_inv_map, 64, 64);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // driver: bursts of beats with random gaps; busy is honored though tied low
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (start && !busy) begin
            cipher_out_q.push_back(des_transform(key_shadow, req_command, req_data_block));
         end
         if (!(start && busy)) begin
            if (gap_left > 0 || pending_q.size() == 0) begin
               start <= 1'b0;
               if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
               beat_type b;
               b = pending_q.pop_front();
               start          <= 1'b1;
               req_command    <= b.cmd;
               req_data_block <= b.blk;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 40);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // monitor: each strobe carries one beat; compare against oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (cipher_out_q.size() == 0) report_mismatch("unexpected result", rsp_result_block, 'x);
         else begin
            logic [63:0] want;
            want = cipher_out_q.pop_front();
            if (rsp_result_block !== want) report_mismatch("result_block", rsp_result_block, want);
         end
      end
      if (cycle_count > MAX_CYCLE) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic queue_beat(logic cmd, logic [63:0] blk);
      beat_type b;
      b.cmd = cmd;
      b.blk = blk;
      pending_q.push_back(b);
   endtask

   // drain the pipe fully, then write the key while idle
   task automatic load_key(logic [63:0] key);
      while (pending_q.size() != 0 || start || cipher_out_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
      csr_write      <= 1'b1;
      csr_cipher_key <= key;
      key_shadow      = key;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      logic [63:0] key_set[6];
      logic [63:0] blk;
      key_set = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1334_5779_9BBC_DFF1,
                  64'h0101_0101_0101_0101, 64'hFEFE_FEFE_FEFE_FEFE, 64'h0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, both commands, known answer, reset key
      for (int c = 0; c < 2; c++) begin
         queue_beat(c[0], 64'h0);
         queue_beat(c[0], 64'hFFFF_FFFF_FFFF_FFFF);
         queue_beat(c[0], 64'h8000_0000_0000_0001);
      end
      load_key(64'h1334_5779_9BBC_DFF1);
      queue_beat(CMD_ENCRYPT, 64'h0123_4567_89AB_CDEF);
      queue_beat(CMD_DECRYPT, 64'h85E8_1354_0F0A_B405);
      // parity bits flipped: same subkeys as above
      load_key(64'h1334_5779_9BBC_DFF1 ^ 64'h0101_0101_0101_0101);
      queue_beat(CMD_ENCRYPT, 64'h0123_4567_89AB_CDEF);
      // weak keys: encrypt twice gives identity
      load_key(64'h0101_0101_0101_0101);
      queue_beat(CMD_ENCRYPT, 64'h0123_4567_89AB_CDEF);
      queue_beat(CMD_DECRYPT, 64'hFFFF_0000_FFFF_0000);
      load_key(64'hFFFF_FFFF_FFFF_FFFF);
      queue_beat(CMD_ENCRYPT, 64'h5555_AAAA_5555_AAAA);

      // random phases, extreme and random keys
      for (int ph = 0; ph < 12; ph++) begin
         load_key(ph < 6 ? key_set[ph] : rand64());
         for (int i = 0; i < 145; i++) begin
            case ($urandom_range(0, 9))
               0: blk = 64'h0;
               1: blk = ~64'h0;
               2: blk = 64'h1 << $urandom_range(0, 63);
               default: blk = rand64();
            endcase
            queue_beat(1'($urandom_range(0, 1)), blk);
         end
      end

      while (pending_q.size() != 0 || start || cipher_out_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      if (error_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
